// ----- hdl/pso_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_pkg
// Shared types and constants of the swarm based MPP search block.
// ----------------------------------------------------------------------------
package pso_pkg;

  localparam int AGENT_COUNT = 4;
  localparam int AIDX_W      = $clog2(AGENT_COUNT);
  localparam int VIS_W       = $clog2(AGENT_COUNT + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_VOLTAGE    = 3'd0,
    CFG_INERTIA_WEIGHT = 3'd1,
    CFG_COGNITIVE_GAIN = 3'd2,
    CFG_SOCIAL_GAIN    = 3'd3,
    CFG_SEARCH_LIMIT   = 3'd4,
    CFG_RNG_SEED       = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic        op;
    logic [15:0] array_voltage;
    logic [15:0] array_current;
  } pso_in_t;

  typedef struct packed {
    logic [15:0] reference_voltage;
    logic        search_done;
    logic [31:0] best_power;
  } pso_out_t;

endpackage

// ----- hdl/pso_global_mppt_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_global_mppt_search
// Global MPP search by a particle swarm with one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one measurement or
//   restart item; the output channel returns exactly one result item for it.
//   in_ready_o is high only while the sequencer is idle; one item is worked
//   on at a time, and a finished result waits in the output register while
//   the next item is already taken.
//   The single 33x18 multiplier forms power, the initial spread and each
//   velocity term in turn.
//   After reset the block draws the initial positions with in_ready_o low;
//   configuration writes are taken throughout.
//   A stalled receiver holds the result; the block then finishes the next
//   item and waits with it until the output register frees.
// ----------------------------------------------------------------------------
module pso_global_mppt_search (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pso_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pso_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pso_pkg::pso_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pso_pkg::pso_out_t                out_data_o
);
  import pso_pkg::*;

  localparam logic [15:0] MV_RST    = 16'd25600;
  localparam logic [15:0] W_RST     = 16'd2048;
  localparam logic [15:0] C1_RST    = 16'd4096;
  localparam logic [15:0] C2_RST    = 16'd4096;
  localparam logic [7:0]  LIM_RST   = 8'd45;
  localparam logic [15:0] SEED_RST  = 16'd44257;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam int          DIV5_MUL  = 52429;
  localparam int          DIV5_SH   = 18;
  localparam int          INTV_W    = 14;
  localparam int          SUM_W     = 17 + AIDX_W;
  localparam int          ACC_W     = 53;
  localparam int          VEL_SH    = 28;

  typedef enum logic [3:0] {
    S_IDLE, S_IINT, S_ISET, S_IDRAW, S_IPOS, S_PMUL, S_REC,
    S_MW, S_MC1, S_MD1, S_MC2, S_MD2, S_VEL, S_OUT
  } state_e;

  state_e                  state_q;
  logic [15:0]             mv_q, w_q, c1_q, c2_q, seed_q;
  logic [7:0]              lim_q;
  logic [15:0]             pos_q [AGENT_COUNT];
  logic signed [17:0]      vel_q [AGENT_COUNT];
  logic [31:0]             pbp_q [AGENT_COUNT];
  logic [15:0]             pbv_q [AGENT_COUNT];
  logic [31:0]             gbp_q;
  logic [15:0]             gbv_q;
  logic [VIS_W-1:0]        visit_q;
  logic                    setup_q, fwd_q;
  logic [7:0]              step_q;
  logic [15:0]             lfsr_q;
  logic [15:0]             init_mv_q;
  logic                    init_out_q;
  logic [AIDX_W-1:0]       idx_q;
  logic [INTV_W-1:0]       intv_q;
  logic [SUM_W-1:0]        base_q;
  logic [15:0]             vin_q, iin_q;
  logic signed [50:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;
  pso_out_t                res_q;
  logic                    out_valid_q;
  pso_out_t                out_q;

  logic signed [32:0]      mul_a;
  logic signed [17:0]      mul_b;
  logic [AIDX_W-1:0]       k;
  logic                    k_ok, k_last;
  logic [15:0]             lfsr_nx;
  logic [15:0]             x;
  logic signed [16:0]      diff1, diff2;
  logic [31:0]             power;
  logic                    pb_up, gb_up;
  logic [31:0]             gbp_new;
  logic signed [ACC_W-1:0] vsh;
  logic signed [17:0]      vel_sat;
  logic signed [18:0]      psum;
  logic [15:0]             pos_new;
  logic                    fwd_n;
  logic [AIDX_W-1:0]       nxt;
  logic [SUM_W-1:0]        init_p;
  logic [15:0]             init_pos;
  logic [7:0]              step_inc;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  function automatic logic [15:0] clamp_mv(input logic [15:0] v, input logic [15:0] m);
    return (v > m) ? m : v;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign k       = visit_q[AIDX_W-1:0];
  assign k_ok    = visit_q < VIS_W'(AGENT_COUNT);
  assign k_last  = (k == AIDX_W'(AGENT_COUNT - 1));
  assign lfsr_nx = lfsr_step(lfsr_q);
  assign x       = pos_q[k];
  assign diff1   = signed'({1'b0, pbv_q[k]}) - signed'({1'b0, x});
  assign diff2   = signed'({1'b0, gbv_q}) - signed'({1'b0, x});
  assign power   = prod_q[31:0];
  assign pb_up   = power > pbp_q[k];
  assign gb_up   = power > gbp_q;
  assign gbp_new = gb_up ? power : gbp_q;
  assign step_inc = (step_q != 8'hFF) ? step_q + 8'd1 : step_q;

  // floor by arithmetic shift, then saturate to 18-bit signed
  assign vsh = acc_q >>> VEL_SH;
  always_comb begin
    vel_sat = vsh[17:0];
    if (!vsh[ACC_W-1] && (|vsh[ACC_W-2:17])) begin
      vel_sat = 18'sd131071;
    end else if (vsh[ACC_W-1] && !(&vsh[ACC_W-2:17])) begin
      vel_sat = -18'sd131072;
    end
  end

  assign psum = signed'({3'b000, x}) + signed'({vel_sat[17], vel_sat});
  always_comb begin
    if (psum[18]) begin
      pos_new = '0;
    end else if (psum > signed'({3'b000, mv_q})) begin
      pos_new = mv_q;
    end else begin
      pos_new = psum[15:0];
    end
  end

  always_comb begin
    fwd_n = fwd_q;
    if (k == '0) begin
      fwd_n = 1'b1;
    end else if (k_last) begin
      fwd_n = 1'b0;
    end
    nxt = fwd_n ? k + AIDX_W'(1) : k - AIDX_W'(1);
  end

  assign init_p   = SUM_W'(prod_q[INTV_W+15:16]) + base_q;
  assign init_pos = (init_p > SUM_W'(init_mv_q)) ? init_mv_q : init_p[15:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_IINT: begin
        mul_a = 33'(DIV5_MUL);
        mul_b = {2'b00, init_mv_q};
      end
      S_IDRAW: begin
        mul_a = {17'b0, lfsr_nx};
        mul_b = {(18 - INTV_W)'(0), intv_q};
      end
      S_PMUL: begin
        mul_a = {17'b0, vin_q};
        mul_b = {2'b00, iin_q};
      end
      S_REC: begin
        mul_a = {17'b0, w_q};
        mul_b = vel_q[k];
      end
      S_MW: begin
        mul_a = {17'b0, c1_q};
        mul_b = {2'b00, lfsr_nx};
      end
      S_MC1: begin
        mul_a = {1'b0, prod_q[31:0]};
        mul_b = {diff1[16], diff1};
      end
      S_MD1: begin
        mul_a = {17'b0, c2_q};
        mul_b = {2'b00, lfsr_nx};
      end
      S_MC2: begin
        mul_a = {1'b0, prod_q[31:0]};
        mul_b = {diff2[16], diff2};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IINT;
      mv_q        <= MV_RST;
      w_q         <= W_RST;
      c1_q        <= C1_RST;
      c2_q        <= C2_RST;
      lim_q       <= LIM_RST;
      seed_q      <= SEED_RST;
      for (int i = 0; i < AGENT_COUNT; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        pbp_q[i] <= '0;
        pbv_q[i] <= '0;
      end
      gbp_q       <= '0;
      gbv_q       <= '0;
      visit_q     <= VIS_W'(AGENT_COUNT);
      setup_q     <= 1'b1;
      fwd_q       <= 1'b1;
      step_q      <= '0;
      lfsr_q      <= SEED_RST;
      init_mv_q   <= MV_RST;
      init_out_q  <= 1'b0;
      idx_q       <= '0;
      intv_q      <= '0;
      base_q      <= '0;
      vin_q       <= '0;
      iin_q       <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      prod_q <= mul_a * mul_b;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_VOLTAGE:    mv_q   <= cfg_data_i;
          CFG_INERTIA_WEIGHT: w_q    <= cfg_data_i;
          CFG_COGNITIVE_GAIN: c1_q   <= cfg_data_i;
          CFG_SOCIAL_GAIN:    c2_q   <= cfg_data_i;
          CFG_SEARCH_LIMIT:   lim_q  <= cfg_data_i[7:0];
          CFG_RNG_SEED:       seed_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            vin_q <= in_data_i.array_voltage;
            iin_q <= in_data_i.array_current;
            if (in_data_i.op) begin
              for (int i = 0; i < AGENT_COUNT; i++) begin
                vel_q[i] <= '0;
                pbp_q[i] <= '0;
                pbv_q[i] <= '0;
              end
              gbp_q      <= '0;
              gbv_q      <= '0;
              visit_q    <= VIS_W'(AGENT_COUNT);
              setup_q    <= 1'b1;
              fwd_q      <= 1'b1;
              step_q     <= '0;
              lfsr_q     <= seed_q;
              init_mv_q  <= mv_q;
              init_out_q <= 1'b1;
              state_q    <= S_IINT;
            end else if (step_q > lim_q) begin
              res_q   <= '{clamp_mv(gbv_q, mv_q), 1'b1, gbp_q};
              state_q <= S_OUT;
            end else if (!k_ok) begin
              visit_q <= '0;
              step_q  <= step_inc;
              res_q   <= '{clamp_mv(pos_q[0], mv_q), 1'b0, gbp_q};
              state_q <= S_OUT;
            end else begin
              state_q <= S_PMUL;
            end
          end
        end
        S_IINT: state_q <= S_ISET;
        S_ISET: begin
          intv_q  <= prod_q[DIV5_SH+INTV_W-1:DIV5_SH];
          base_q  <= '0;
          idx_q   <= '0;
          state_q <= S_IDRAW;
        end
        S_IDRAW: begin
          lfsr_q  <= lfsr_nx;
          state_q <= S_IPOS;
        end
        S_IPOS: begin
          pos_q[idx_q] <= init_pos;
          base_q       <= base_q + SUM_W'(intv_q);
          if (idx_q == AIDX_W'(AGENT_COUNT - 1)) begin
            init_out_q <= 1'b0;
            if (init_out_q) begin
              res_q   <= '{clamp_mv(pos_q[0], mv_q), 1'b0, 32'd0};
              state_q <= S_OUT;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            idx_q   <= idx_q + AIDX_W'(1);
            state_q <= S_IDRAW;
          end
        end
        S_PMUL: state_q <= S_REC;
        S_REC: begin
          if (pb_up) begin
            pbp_q[k] <= power;
            pbv_q[k] <= vin_q;
          end
          if (gb_up) begin
            gbp_q <= power;
            gbv_q <= vin_q;
          end
          if (setup_q) begin
            step_q  <= step_inc;
            state_q <= S_OUT;
            if (k_last) begin
              setup_q <= 1'b0;
              fwd_q   <= 1'b0;
              visit_q <= VIS_W'(AGENT_COUNT - 2);
              res_q   <= '{clamp_mv(pos_q[AGENT_COUNT-2], mv_q), 1'b0, gbp_new};
            end else begin
              visit_q <= VIS_W'(k) + VIS_W'(1);
              res_q   <= '{clamp_mv(pos_q[k + AIDX_W'(1)], mv_q), 1'b0, gbp_new};
            end
          end else begin
            state_q <= S_MW;
          end
        end
        S_MW: begin
          acc_q   <= ACC_W'(prod_q) <<< 16;
          lfsr_q  <= lfsr_nx;
          state_q <= S_MC1;
        end
        S_MC1: state_q <= S_MD1;
        S_MD1: begin
          acc_q   <= acc_q + ACC_W'(prod_q);
          lfsr_q  <= lfsr_nx;
          state_q <= S_MC2;
        end
        S_MC2: state_q <= S_MD2;
        S_MD2: begin
          acc_q   <= acc_q + ACC_W'(prod_q);
          state_q <= S_VEL;
        end
        S_VEL: begin
          vel_q[k] <= vel_sat;
          pos_q[k] <= pos_new;
          fwd_q    <= fwd_n;
          visit_q  <= VIS_W'(nxt);
          step_q   <= step_inc;
          res_q    <= '{clamp_mv(pos_q[nxt], mv_q), 1'b0, gbp_q};
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/pso_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_checker
// Port level checks of the swarm MPP search block, bound to its top level.
// ----------------------------------------------------------------------------
module pso_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input pso_pkg::pso_out_t                out_data_o
);

  logic       in_acc, out_acc;
  logic [1:0] inflight_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // items taken minus results delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready right after an accepted item");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 2'd0)
    else $error("result without an item in flight");

  a_one_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> inflight_q <= 2'd1)
    else $error("more than one item ahead of the output");

endmodule

bind pso_global_mppt_search pso_checker u_pso_checker (.*);

// ----- verif/pso_global_mppt_search_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_global_mppt_search_tb
// Self-checking bench for the swarm based global MPP search block. A model of
// the four-agent swarm (LFSR draws, bounce order, velocity rule, best
// tracking, step limit) runs alongside the block, predicts every result item
// and checks it field by field. Directed items cover the start step, the
// setup sweep, ties, restarts, the finished search and extreme registers;
// random runs of restart plus measurements follow under varied settings,
// random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module pso_global_mppt_search_tb;
  import pso_pkg::*;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_RESTART = 1'b1;
  localparam int   HOLD_CYCLES    = 400;
  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   RANDOM_ITEMS   = 1360;
  localparam longint VEL_HI = 131071;
  localparam longint VEL_LO = -131072;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  pso_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  pso_out_t              out_data_o;

  pso_global_mppt_search DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // register shadow
  logic [15:0] cfg_vmax, cfg_inertia, cfg_cog, cfg_soc, cfg_seed;
  logic [7:0]  cfg_limit;

  // swarm model state
  logic [15:0]        pos_m   [AGENT_COUNT];
  logic signed [17:0] vel_m   [AGENT_COUNT];
  logic [31:0]        pbest_p [AGENT_COUNT];
  logic [15:0]        pbest_v [AGENT_COUNT];
  logic [31:0]        gbest_p;
  logic [15:0]        gbest_v;
  int                 visit;
  bit                 sweeping, fwd;
  logic [7:0]         steps;
  logic [15:0]        lfsr;

  pso_out_t pending_cmds[$];

  bit tx_gaps, rx_gaps, hold_req;
  int mismatch_cnt, item_cnt, restart_cnt, checked_cnt, done_cnt, velocity_cnt;
  int setting_cnt, quiet_cycles;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] lfsr_draw();
    lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? 16'hB400 : 16'h0000);
    return lfsr;
  endfunction

  function automatic void spread_agents();
    longint span, p;
    span = cfg_vmax / 5;
    lfsr = cfg_seed;
    for (int i = 0; i < AGENT_COUNT; i++) begin
      p = ((longint'(lfsr_draw()) * span) >> 16) + span * i;
      pos_m[i]   = (p > cfg_vmax) ? cfg_vmax : p[15:0];
      vel_m[i]   = '0;
      pbest_p[i] = '0;
      pbest_v[i] = '0;
    end
    gbest_p  = '0;
    gbest_v  = '0;
    visit    = AGENT_COUNT;
    sweeping = 1'b1;
    fwd      = 1'b1;
    steps    = '0;
  endfunction

  function automatic void note_best(int k, logic [31:0] power, logic [15:0] volt);
    if (power > pbest_p[k]) begin
      pbest_p[k] = power;
      pbest_v[k] = volt;
    end
    if (power > gbest_p) begin
      gbest_p = power;
      gbest_v = volt;
    end
  endfunction

  function automatic void move_agent(int k);
    longint x, r1, r2, sum, v, p;
    x   = pos_m[k];
    r1  = lfsr_draw();
    r2  = lfsr_draw();
    sum = longint'(cfg_inertia) * longint'(vel_m[k]) * 65536
        + longint'(cfg_cog) * r1 * (longint'(pbest_v[k]) - x)
        + longint'(cfg_soc) * r2 * (longint'(gbest_v) - x);
    v = sum >>> 28;
    if (v > VEL_HI) v = VEL_HI;
    if (v < VEL_LO) v = VEL_LO;
    vel_m[k] = v[17:0];
    p = x + v;
    if (p < 0) p = 0;
    if (p > cfg_vmax) p = cfg_vmax;
    pos_m[k] = p[15:0];
    velocity_cnt++;
  endfunction

  function automatic pso_out_t predict_item(input pso_in_t it);
    pso_out_t    res;
    logic [31:0] power;
    logic [15:0] cmd_v;
    int          k, nxt;
    power = it.array_voltage * it.array_current;
    res.search_done = 1'b0;
    if (it.op == OP_RESTART) begin
      spread_agents();
      restart_cnt++;
      cmd_v = pos_m[0];
    end else if (steps > cfg_limit) begin
      res.search_done = 1'b1;
      cmd_v = gbest_v;
    end else begin
      k = visit;
      if (k >= AGENT_COUNT) begin
        nxt = 0;
      end else if (sweeping) begin
        note_best(k, power, it.array_voltage);
        if (k + 1 < AGENT_COUNT) begin
          nxt = k + 1;
        end else begin
          sweeping = 1'b0;
          fwd      = 1'b0;
          nxt      = AGENT_COUNT - 2;
        end
      end else begin
        note_best(k, power, it.array_voltage);
        move_agent(k);
        if (k == 0) fwd = 1'b1;
        else if (k == AGENT_COUNT - 1) fwd = 1'b0;
        nxt = fwd ? k + 1 : k - 1;
      end
      visit = nxt;
      if (steps != 8'd255) steps++;
      cmd_v = pos_m[nxt];
    end
    res.reference_voltage = (cmd_v > cfg_vmax) ? cfg_vmax : cmd_v;
    res.best_power        = gbest_p;
    return res;
  endfunction

  function automatic pso_in_t mk_item(logic op, logic [15:0] volt, logic [15:0] curr);
    pso_in_t it;
    it.op            = op;
    it.array_voltage = volt;
    it.array_current = curr;
    return it;
  endfunction

  // mostly plausible readings inside the voltage window, some full range
  function automatic pso_in_t rand_meas();
    if ($urandom_range(0, 9) == 0)
      return mk_item(OP_MEASURE, 16'($urandom), 16'($urandom));
    return mk_item(OP_MEASURE, 16'($urandom_range(0, cfg_vmax)),
                   16'($urandom_range(0, 16'hFFFF)));
  endfunction

  task automatic write_cfg(input cfg_reg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_MAX_VOLTAGE:    cfg_vmax    = val;
      CFG_INERTIA_WEIGHT: cfg_inertia = val;
      CFG_COGNITIVE_GAIN: cfg_cog     = val;
      CFG_SOCIAL_GAIN:    cfg_soc     = val;
      CFG_SEARCH_LIMIT:   cfg_limit   = val[7:0];
      CFG_RNG_SEED:       cfg_seed    = val;
      default: ;
    endcase
  endtask

  task automatic send_item(input pso_in_t item);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    pending_cmds.insert(pending_cmds.size(), predict_item(item));
    item_cnt++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_start_and_sweep();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_item(mk_item(OP_MEASURE, 16'hFFFF, 16'hFFFF));
    send_item(mk_item(OP_MEASURE, 16'h0000, 16'h0000));
    send_item(mk_item(OP_MEASURE, 16'h1900, 16'h0400));
    send_item(mk_item(OP_MEASURE, 16'h1900, 16'h0400));
    send_item(mk_item(OP_MEASURE, 16'hFFFF, 16'hFFFF));
    repeat (3) send_item(rand_meas());
    send_item(mk_item(OP_RESTART, 16'hFFFF, 16'hFFFF));
    drain();
  endtask

  task automatic test_restart_and_finish();
    write_cfg(CFG_SEARCH_LIMIT, 16'd1);
    send_item(mk_item(OP_RESTART, 16'h0000, 16'h0000));
    send_item(mk_item(OP_MEASURE, 16'h0100, 16'h0100));
    send_item(mk_item(OP_MEASURE, 16'h2000, 16'h0300));
    repeat (2) send_item(rand_meas());
    send_item(mk_item(OP_RESTART, 16'h1234, 16'h5678));
    send_item(rand_meas());
    drain();
  endtask

  task automatic test_register_extremes();
    write_cfg(CFG_MAX_VOLTAGE, 16'hFFFF);
    write_cfg(CFG_INERTIA_WEIGHT, 16'hFFFF);
    write_cfg(CFG_COGNITIVE_GAIN, 16'hFFFF);
    write_cfg(CFG_SOCIAL_GAIN, 16'hFFFF);
    write_cfg(CFG_RNG_SEED, 16'hFFFF);
    write_cfg(CFG_SEARCH_LIMIT, 16'd255);
    send_item(mk_item(OP_RESTART, 16'h0000, 16'h0000));
    send_item(mk_item(OP_MEASURE, 16'h0000, 16'h0000));
    send_item(mk_item(OP_MEASURE, 16'hFFFF, 16'h0001));
    send_item(mk_item(OP_MEASURE, 16'h0001, 16'hFFFF));
    send_item(mk_item(OP_MEASURE, 16'hFFFF, 16'hFFFF));
    send_item(mk_item(OP_MEASURE, 16'h8000, 16'h8000));
    repeat (2) send_item(rand_meas());
    drain();
    write_cfg(CFG_MAX_VOLTAGE, 16'h0000);
    write_cfg(CFG_RNG_SEED, 16'h0001);
    send_item(mk_item(OP_RESTART, 16'hFFFF, 16'h0000));
    repeat (2) send_item(rand_meas());
    drain();
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'h3000));
    endcase
  endfunction

  task automatic test_random_search(input int total);
    int left, budget, run_len, ph;
    left = total;
    ph = 0;
    while (left > 0) begin
      case ($urandom_range(0, 4))
        0:       write_cfg(CFG_MAX_VOLTAGE, 16'hFFFF);
        1:       write_cfg(CFG_MAX_VOLTAGE, 16'($urandom_range(1, 50)));
        default: write_cfg(CFG_MAX_VOLTAGE, 16'($urandom_range(1000, 16'hFFFF)));
      endcase
      write_cfg(CFG_INERTIA_WEIGHT, pick_gain());
      write_cfg(CFG_COGNITIVE_GAIN, pick_gain());
      write_cfg(CFG_SOCIAL_GAIN, pick_gain());
      if (ph == 2)
        write_cfg(CFG_SEARCH_LIMIT, 16'd255);
      else if ($urandom_range(0, 4) == 0)
        write_cfg(CFG_SEARCH_LIMIT, 16'd1);
      else
        write_cfg(CFG_SEARCH_LIMIT, 16'($urandom_range(2, 60)));
      case ($urandom_range(0, 5))
        0:       write_cfg(CFG_RNG_SEED, 16'h0001);
        1:       write_cfg(CFG_RNG_SEED, 16'hFFFF);
        default: write_cfg(CFG_RNG_SEED, 16'($urandom_range(1, 16'hFFFF)));
      endcase
      setting_cnt++;
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      budget = (cfg_limit == 8'd255) ? 320 : $urandom_range(100, 180);
      if (budget > left) budget = left;
      left -= budget;
      // the opening run may carry on from the previous settings
      if (ph == 0 || $urandom_range(0, 2) != 0) begin
        send_item(mk_item(OP_RESTART, 16'($urandom), 16'($urandom)));
        budget--;
      end
      while (budget > 0) begin
        run_len = (cfg_limit == 8'd255) ? budget : $urandom_range(1, cfg_limit + 12);
        while (run_len > 0 && budget > 0) begin
          if ($urandom_range(0, 49) == 0)
            send_item(mk_item(OP_RESTART, 16'($urandom), 16'($urandom)));
          else
            send_item(rand_meas());
          run_len--;
          budget--;
        end
        if (budget > 0) begin
          send_item(mk_item(OP_RESTART, 16'($urandom), 16'($urandom)));
          budget--;
        end
      end
      drain();
      ph++;
    end
  endtask

  task automatic test_output_stall();
    tx_gaps  = 1'b0;
    rx_gaps  = 1'b0;
    hold_req = 1'b1;
    send_item(mk_item(OP_RESTART, 16'h0000, 16'h0000));
    repeat (11) send_item(rand_meas());
    drain();
  endtask

  // receiver: random back-pressure, plus one long hold on request
  initial begin : rx_drive
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 9) < 3) begin
        out_ready_i <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    pso_out_t want;
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_cmds.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t MISMATCH unexpected result item 0x%0h", $time, out_data_o);
      end else begin
        want = pending_cmds.pop_front();
        checked_cnt++;
        if (want.search_done) done_cnt++;
        if (out_data_o.reference_voltage !== want.reference_voltage)
          flag_mismatch("reference_voltage", 64'(want.reference_voltage),
                        64'(out_data_o.reference_voltage));
        if (out_data_o.search_done !== want.search_done)
          flag_mismatch("search_done", 64'(want.search_done),
                        64'(out_data_o.search_done));
        if (out_data_o.best_power !== want.best_power)
          flag_mismatch("best_power", 64'(want.best_power),
                        64'(out_data_o.best_power));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results outstanding",
               quiet_cycles, pending_cmds.size());
      $display("pso_global_mppt_search_tb failed");
      $finish;
    end
  end

  initial begin : run_tests
    repeat (12) @(posedge clk_i);
    rst_ni      <= 1'b1;
    cfg_vmax    = 16'd25600;
    cfg_inertia = 16'd2048;
    cfg_cog     = 16'd4096;
    cfg_soc     = 16'd4096;
    cfg_limit   = 8'd45;
    cfg_seed    = 16'd44257;
    spread_agents();
    // initial draws run with ready low
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    test_start_and_sweep();
    test_restart_and_finish();
    test_register_extremes();
    test_random_search(RANDOM_ITEMS);
    test_output_stall();
    repeat (30) @(posedge clk_i);
    $display("Sent %0d items (%0d restarts) under %0d random register settings,",
             item_cnt, restart_cnt, setting_cnt);
    $display("checked %0d results: %0d velocity updates, %0d after search end.",
             checked_cnt, velocity_cnt, done_cnt);
    if (mismatch_cnt == 0 && pending_cmds.size() == 0) begin
      $display("pso_global_mppt_search_tb passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_cnt,
               pending_cmds.size());
      $display("pso_global_mppt_search_tb failed");
    end
    $finish;
  end

endmodule
